// File: sv/mtep_pkg.sv
// Package for the MIDI track event parser.
// Holds the parse phase type, result kind codes and byte constants.
// No dependencies.
`default_nettype none

package mtep_pkg;

    // Parse phase, one-hot coded
    typedef enum logic [7:0] {
        PH_DELTA     = 8'b0000_0001,
        PH_STATUS    = 8'b0000_0010,
        PH_DATA1     = 8'b0000_0100,
        PH_DATA2     = 8'b0000_1000,
        PH_META_TYPE = 8'b0001_0000,
        PH_LENGTH    = 8'b0010_0000,
        PH_PAYLOAD   = 8'b0100_0000,
        PH_ENDED     = 8'b1000_0000
    } t_phase;

    typedef logic [1:0] t_kind;

    // Result kinds
    localparam t_kind KIND_CHANNEL = 2'd0;
    localparam t_kind KIND_HEADER  = 2'd1;
    localparam t_kind KIND_PAYLOAD = 2'd2;

    // Byte codes
    localparam logic [7:0] META_STATUS   = 8'hFF;
    localparam logic [7:0] META_EOT      = 8'h2F;
    localparam logic [3:0] SYSTEM_NIBBLE = 4'hF;

    // Running status nibbles
    localparam logic [3:0] RS_NOTE_OFF  = 4'h8;
    localparam logic [3:0] RS_NOTE_ON   = 4'h9;
    localparam logic [3:0] RS_AFTERTCH  = 4'hA;
    localparam logic [3:0] RS_CONTROL   = 4'hB;
    localparam logic [3:0] RS_PROGRAM   = 4'hC;
    localparam logic [3:0] RS_PRESSURE  = 4'hD;
    localparam logic [3:0] RS_PITCH     = 4'hE;

endpackage

`default_nettype wire

// File: sv/mtep_in_if.sv
// Input channel of the MIDI track event parser: one track byte per transaction.
// Depends on nothing.
`default_nettype none

interface mtep_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_of_track;

    modport source (output valid, output data_byte, output first_of_track, input ready);
    modport sink   (input valid, input data_byte, input first_of_track, output ready);
endinterface

`default_nettype wire

// File: sv/mtep_out_if.sv
// Result channel of the MIDI track event parser: one parsed event per transaction.
// Depends on nothing.
`default_nettype none

interface mtep_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [31:0] event_time;
    logic [7:0]  status;
    logic [7:0]  data1;
    logic [6:0]  data2;
    logic [31:0] payload_length;
    logic        track_done;

    modport source (output valid, output kind, output event_time, output status,
                    output data1, output data2, output payload_length,
                    output track_done, input ready);
    modport sink   (input valid, input kind, input event_time, input status,
                    input data1, input data2, input payload_length,
                    input track_done, output ready);
endinterface

`default_nettype wire

// File: sv/midi_track_event_parser.sv
// Standard MIDI File track body parser, one byte per transaction.
// Depends on mtep_pkg, mtep_in_if and mtep_out_if.
//
//   Channel  Dir  Transaction       Fields
//   i_in     in   one track byte    data_byte, first_of_track
//   o_out    out  one parsed event  kind, event_time, status, data1, data2,
//                                   payload_length, track_done
//
// One byte per cycle while the sink keeps up; a result appears in the cycle after
// the byte that completes it. All parse state updates in the accepting cycle and the
// result goes to a single output register. i_in.ready is high whenever that
// register is empty or being drained, so a stalled sink stalls the input.
// i_rst_n (synchronous, active low) clears all parse state and the output valid flag.
`default_nettype none

module midi_track_event_parser (
    input  wire        i_clk,
    input  wire        i_rst_n,
    mtep_in_if.sink    i_in,
    mtep_out_if.source o_out
);

    // Parse state
    mtep_pkg::t_phase r_phase,   n_phase;
    logic [31:0]      r_abs,     n_abs;
    logic [31:0]      r_acc,     n_acc;
    logic [3:0]       r_rs,      n_rs;
    logic [3:0]       r_ch,      n_ch;
    logic [6:0]       r_held_d1, n_held_d1;
    logic [7:0]       r_held_ev, n_held_ev;
    logic [7:0]       r_held_mt, n_held_mt;
    logic [31:0]      r_left,    n_left;

    // Result register
    logic              r_out_valid;
    mtep_pkg::t_kind   r_kind,   n_kind;
    logic [31:0]       r_time,   n_time;
    logic [7:0]        r_status, n_status;
    logic [7:0]        r_data1,  n_data1;
    logic [6:0]        r_data2,  n_data2;
    logic [31:0]       r_len,    n_len;
    logic              r_done,   n_done;
    logic              n_emit;

    // State as seen by this byte, after a first-of-track clear
    mtep_pkg::t_phase e_phase;
    logic [31:0]      e_abs;
    logic [31:0]      e_acc;
    logic [3:0]       e_rs;
    logic [3:0]       e_ch;
    logic [7:0]       e_held_ev;
    logic [7:0]       e_held_mt;
    logic [31:0]      e_left;

    logic [7:0]  c;
    logic [31:0] vlq_next;
    logic [31:0] left_dec;
    logic        accept;
    logic        eot;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;
    assign c          = i_in.data_byte;

    // Apply first-of-track clear
    always_comb begin
        if (i_in.first_of_track) begin
            e_phase   = mtep_pkg::PH_DELTA;
            e_abs     = '0;
            e_acc     = '0;
            e_rs      = '0;
            e_ch      = '0;
            e_held_ev = '0;
            e_held_mt = '0;
            e_left    = '0;
        end else begin
            e_phase   = r_phase;
            e_abs     = r_abs;
            e_acc     = r_acc;
            e_rs      = r_rs;
            e_ch      = r_ch;
            e_held_ev = r_held_ev;
            e_held_mt = r_held_mt;
            e_left    = r_left;
        end
    end

    // Shift in seven bits of a variable-length quantity
    assign vlq_next = {e_acc[24:0], c[6:0]};
    assign left_dec = e_left - {31'd0, (e_left != '0)};
    assign eot      = (e_held_ev == mtep_pkg::META_STATUS) &&
                      (e_held_mt == mtep_pkg::META_EOT);

    // Advance parse state and build the result
    always_comb begin
        n_phase   = e_phase;
        n_abs     = e_abs;
        n_acc     = e_acc;
        n_rs      = e_rs;
        n_ch      = e_ch;
        n_held_d1 = i_in.first_of_track ? 7'd0 : r_held_d1;
        n_held_ev = e_held_ev;
        n_held_mt = e_held_mt;
        n_left    = e_left;
        n_emit    = 1'b0;
        n_kind    = mtep_pkg::KIND_CHANNEL;
        n_time    = e_abs;
        n_status  = {e_rs, e_ch};
        n_data1   = {1'b0, c[6:0]};
        n_data2   = '0;
        n_len     = '0;
        n_done    = 1'b0;

        case (e_phase)
            mtep_pkg::PH_DELTA: begin
                n_acc = vlq_next;
                if (!c[7]) begin
                    n_abs   = e_abs + vlq_next;
                    n_acc   = '0;
                    n_phase = mtep_pkg::PH_STATUS;
                end
            end
            mtep_pkg::PH_STATUS, mtep_pkg::PH_DATA1: begin
                if (e_phase == mtep_pkg::PH_STATUS &&
                    c[7:4] == mtep_pkg::SYSTEM_NIBBLE) begin
                    n_held_ev = c;
                    if (c == mtep_pkg::META_STATUS) begin
                        n_phase = mtep_pkg::PH_META_TYPE;
                    end else begin
                        n_held_mt = '0;
                        n_acc     = '0;
                        n_phase   = mtep_pkg::PH_LENGTH;
                    end
                end else if (e_phase == mtep_pkg::PH_STATUS && c[7]) begin
                    n_ch    = c[3:0];
                    n_rs    = c[7:4];
                    n_phase = mtep_pkg::PH_DATA1;
                end else begin
                    // First data byte, after a status byte or under running status
                    case (e_rs) inside
                        mtep_pkg::RS_NOTE_OFF, mtep_pkg::RS_NOTE_ON,
                        mtep_pkg::RS_AFTERTCH, mtep_pkg::RS_CONTROL,
                        mtep_pkg::RS_PITCH: begin
                            n_held_d1 = c[6:0];
                            n_phase   = mtep_pkg::PH_DATA2;
                        end
                        mtep_pkg::RS_PROGRAM, mtep_pkg::RS_PRESSURE: begin
                            n_emit  = 1'b1;
                            n_phase = mtep_pkg::PH_DELTA;
                        end
                        default: begin
                            n_phase = mtep_pkg::PH_DELTA;
                        end
                    endcase
                end
            end
            mtep_pkg::PH_DATA2: begin
                n_emit  = 1'b1;
                n_data1 = {1'b0, r_held_d1};
                n_data2 = c[6:0];
                n_phase = mtep_pkg::PH_DELTA;
            end
            mtep_pkg::PH_META_TYPE: begin
                n_held_mt = c;
                n_acc     = '0;
                n_phase   = mtep_pkg::PH_LENGTH;
            end
            mtep_pkg::PH_LENGTH: begin
                n_acc = vlq_next;
                if (!c[7]) begin
                    n_emit   = 1'b1;
                    n_kind   = mtep_pkg::KIND_HEADER;
                    n_status = e_held_ev;
                    n_data1  = e_held_mt;
                    n_len    = vlq_next;
                    n_done   = eot;
                    n_left   = vlq_next;
                    n_acc    = '0;
                    if (eot) begin
                        n_phase = mtep_pkg::PH_ENDED;
                    end else if (vlq_next == '0) begin
                        n_phase = mtep_pkg::PH_DELTA;
                    end else begin
                        n_phase = mtep_pkg::PH_PAYLOAD;
                    end
                end
            end
            mtep_pkg::PH_PAYLOAD: begin
                n_emit   = 1'b1;
                n_kind   = mtep_pkg::KIND_PAYLOAD;
                n_status = e_held_ev;
                n_data1  = c;
                n_left   = left_dec;
                if (left_dec == '0) begin
                    n_phase = mtep_pkg::PH_DELTA;
                end
            end
            default: begin
                n_phase = mtep_pkg::PH_ENDED;
            end
        endcase
    end

    // Hold parse state; update on each accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= mtep_pkg::PH_DELTA;
            r_abs     <= '0;
            r_acc     <= '0;
            r_rs      <= '0;
            r_ch      <= '0;
            r_held_d1 <= '0;
            r_held_ev <= '0;
            r_held_mt <= '0;
            r_left    <= '0;
        end else if (accept) begin
            r_phase   <= n_phase;
            r_abs     <= n_abs;
            r_acc     <= n_acc;
            r_rs      <= n_rs;
            r_ch      <= n_ch;
            r_held_d1 <= n_held_d1;
            r_held_ev <= n_held_ev;
            r_held_mt <= n_held_mt;
            r_left    <= n_left;
        end
    end

    // Output register valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && n_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Load result payload
    always_ff @(posedge i_clk) begin
        if (accept && n_emit) begin
            r_kind   <= n_kind;
            r_time   <= n_time;
            r_status <= n_status;
            r_data1  <= n_data1;
            r_data2  <= n_data2;
            r_len    <= n_len;
            r_done   <= n_done;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.kind           = r_kind;
    assign o_out.event_time     = r_time;
    assign o_out.status         = r_status;
    assign o_out.data1          = r_data1;
    assign o_out.data2          = r_data2;
    assign o_out.payload_length = r_len;
    assign o_out.track_done     = r_done;

    // End of track is only flagged on an FF 2F header
    a_done_is_eot_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.track_done) |->
        (o_out.kind == mtep_pkg::KIND_HEADER && o_out.status == mtep_pkg::META_STATUS &&
         o_out.data1 == mtep_pkg::META_EOT))
        else $error("track_done on a result that is not an end-of-track header");

    // Second data byte only on channel messages, length only on headers
    a_field_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |->
        ((o_out.kind == mtep_pkg::KIND_CHANNEL || o_out.data2 == '0) &&
         (o_out.kind == mtep_pkg::KIND_HEADER || o_out.payload_length == '0)))
        else $error("unexpected nonzero data2 or payload_length");

    // Once ended, a track stays ended until the next first byte
    a_ended_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !i_in.first_of_track && r_phase == mtep_pkg::PH_ENDED) |=>
        (r_phase == mtep_pkg::PH_ENDED))
        else $error("parser left the ended phase without a new track");

    // Channel messages carry a channel status byte
    a_channel_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.kind == mtep_pkg::KIND_CHANNEL) |->
        (o_out.status[7] && o_out.status[7:4] != mtep_pkg::SYSTEM_NIBBLE))
        else $error("channel message without a channel status byte");

endmodule

`default_nettype wire
